// ===== hw/rtl/rhc_pkg.sv =====
// shared constants, types and helpers for the rgb to hsv converter
package rhc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CH_W      = 16;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int HUE_W     = FRAC_BITS;
  localparam int DIV_W     = FRAC_BITS + 3;
  localparam int REM_W     = DIV_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int FRONT_LAT = 3;
  localparam int LATENCY   = FRONT_LAT + DIV_STEPS;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] div;
    logic [QUO_W-1:0] quo;
  } rhc_lane_t;

  typedef struct packed {
    logic             valid;
    rhc_lane_t        hue;
    rhc_lane_t        sat;
    logic [LVL_W-1:0] value;
    logic [LVL_W-1:0] alpha;
  } rhc_pipe_t;

  function automatic logic [LVL_W-1:0] clamp_unit(input logic [CH_W-1:0] v);
    logic [LVL_W-1:0] res;
    if (v[CH_W-1]) begin
      res = '0;
    end else if (v[CH_W-2:0] >= (CH_W-1)'(ONE)) begin
      res = LVL_W'(ONE);
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rhc_front.sv =====
// clamp, max/min search and hue numerator set-up, three register stages
module rhc_front import rhc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  input  logic [CH_W-1:0] alpha,
  output rhc_pipe_t       front_out
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // stage 1 registers
  logic             s1_valid;
  logic [LVL_W-1:0] s1_r, s1_g, s1_b, s1_a;

  // stage 2 registers
  logic               s2_valid;
  logic [LVL_W-1:0]   s2_mx, s2_delta, s2_a;
  logic signed [LVL_W:0] s2_diff;
  sector_t            s2_sec;

  // stage 2 logic
  logic [LVL_W-1:0]   mx_c, mn_c;
  logic signed [LVL_W:0] diff_c;
  sector_t            sec_c;

  // stage 3 logic
  logic [DIV_W-1:0]        off_c, d6_c;
  logic signed [REM_W-1:0] t_sum, t_wrap;
  rhc_pipe_t               front_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      front_out.valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      front_out.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= clamp_unit(red);
    s1_g <= clamp_unit(green);
    s1_b <= clamp_unit(blue);
    s1_a <= clamp_unit(alpha);
  end

  // red wins ties over green, green over blue
  always_comb begin
    if (s1_r >= s1_g && s1_r >= s1_b) begin
      sec_c  = SEC_RED;
      mx_c   = s1_r;
      diff_c = $signed({1'b0, s1_g}) - $signed({1'b0, s1_b});
    end else if (s1_g >= s1_b) begin
      sec_c  = SEC_GREEN;
      mx_c   = s1_g;
      diff_c = $signed({1'b0, s1_b}) - $signed({1'b0, s1_r});
    end else begin
      sec_c  = SEC_BLUE;
      mx_c   = s1_b;
      diff_c = $signed({1'b0, s1_r}) - $signed({1'b0, s1_g});
    end
    mn_c = s1_r;
    if (s1_g < mn_c) mn_c = s1_g;
    if (s1_b < mn_c) mn_c = s1_b;
  end

  always_ff @(posedge clk) begin
    s2_mx    <= mx_c;
    s2_delta <= mx_c - mn_c;
    s2_diff  <= diff_c;
    s2_sec   <= sec_c;
    s2_a     <= s1_a;
  end

  always_comb begin
    case (s2_sec)
      SEC_GREEN: off_c = DIV_W'({s2_delta, 1'b0});
      SEC_BLUE:  off_c = DIV_W'({s2_delta, 2'b00});
      default:   off_c = '0;
    endcase
    d6_c   = DIV_W'({s2_delta, 2'b00}) + DIV_W'({s2_delta, 1'b0});
    t_sum  = $signed({1'b0, off_c})
           + $signed({{(REM_W-LVL_W-1){s2_diff[LVL_W]}}, s2_diff});
    t_wrap = t_sum[REM_W-1] ? t_sum + $signed({1'b0, d6_c}) : t_sum;

    front_next       = '0;
    front_next.value = s2_mx;
    front_next.alpha = s2_a;
    // gray pixel: zero numerators over unit divisors give zero quotients
    if (s2_delta == '0) begin
      front_next.hue.div = DIV_W'(1);
      front_next.sat.div = DIV_W'(1);
    end else begin
      front_next.hue.rem = REM_W'(t_wrap);
      front_next.hue.div = d6_c;
      front_next.sat.rem = REM_W'(s2_delta);
      front_next.sat.div = DIV_W'(s2_mx);
    end
  end

  always_ff @(posedge clk) begin
    front_out.hue   <= front_next.hue;
    front_out.sat   <= front_next.sat;
    front_out.value <= front_next.value;
    front_out.alpha <= front_next.alpha;
  end

endmodule

// ===== hw/rtl/rhc_div_step.sv =====
// one restoring division step for the hue and saturation lanes
module rhc_div_step import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rhc_pipe_t stage_in,
  output rhc_pipe_t stage_out
);

  function automatic rhc_lane_t lane_step(input rhc_lane_t l);
    rhc_lane_t        res;
    logic             ge;
    logic [REM_W-1:0] diff;
    ge   = l.rem >= {1'b0, l.div};
    diff = l.rem - {1'b0, l.div};
    res.div = l.div;
    res.quo = {l.quo[QUO_W-2:0], ge};
    res.rem = ge ? {diff[REM_W-2:0], 1'b0} : {l.rem[REM_W-2:0], 1'b0};
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_out.hue   <= lane_step(stage_in.hue);
    stage_out.sat   <= lane_step(stage_in.sat);
    stage_out.value <= stage_in.value;
    stage_out.alpha <= stage_in.alpha;
  end

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// top level of the rgb to hsv converter
// Takes one pixel word per clock whenever start is high (busy is always low)
// and gives its result with done high for one cycle: three front stages
// clamp the channels, find max and min and set up the hue numerator,
// then thirteen restoring division stages produce one quotient bit each
// for hue and saturation side by side. The receiver cannot stall, so
// results leave at the same rate words enter.
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  logic [CH_W-1:0]  alpha,
  output logic             done,
  output logic [HUE_W-1:0] hue,
  output logic [LVL_W-1:0] saturation,
  output logic [LVL_W-1:0] value,
  output logic [LVL_W-1:0] alpha_out
);

  rhc_pipe_t pipe [DIV_STEPS+1];

  assign busy = 1'b0;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .front_out (pipe[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rhc_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (pipe[i]),
      .stage_out (pipe[i+1])
    );
  end

  assign done       = pipe[DIV_STEPS].valid;
  assign hue        = pipe[DIV_STEPS].hue.quo[HUE_W-1:0];
  assign saturation = pipe[DIV_STEPS].sat.quo;
  assign value      = pipe[DIV_STEPS].value;
  assign alpha_out  = pipe[DIV_STEPS].alpha;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##16 done)
    else $error("word did not come out after the pipeline latency");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && value == '0) |-> (saturation == '0 && hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (saturation <= LVL_W'(ONE) && saturation <= value
              || saturation <= LVL_W'(ONE) && value != '0))
    else $error("saturation out of range");

  a_hue_top: assert property (@(posedge clk) disable iff (rst)
    done |-> pipe[DIV_STEPS].hue.quo[QUO_W-1] == 1'b0)
    else $error("hue quotient reached a full turn");

endmodule
